/* design/pfde_pkg.sv */
// Shared types, constants and lookup functions for the Playfair digraph encryptor.
package pfde_pkg;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] coord_t;
	typedef logic [6:0] ascii_t;

	// Key square, indexed [row][col]
	typedef letter_t [4:0][4:0] square_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	// One digraph waiting for encryption
	typedef struct packed {
		letter_t first;
		letter_t second;
		logic    twice;  // digraph is emitted two times (doubled letter at end)
		logic    last;   // digraph closes the message
	} job_t;

	localparam letter_t LETTER_I = 5'd8;
	localparam letter_t LETTER_J = 5'd9;
	localparam letter_t LETTER_X = 5'd23;
	localparam letter_t LETTER_Z = 5'd25;
	localparam ascii_t  ASCII_A  = 7'd65;
	localparam coord_t  LAST_POS = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_ROWS_01 = 2'd0;
	localparam logic [1:0] REG_ROWS_23 = 2'd1;
	localparam logic [1:0] REG_ROW_4   = 2'd2;

	// Reset square: lgdba / qmhec / urnif / xvsok / zywtp
	localparam logic [49:0] RST_ROWS_01 = 50'd75020730666187;
	localparam logic [49:0] RST_ROWS_23 = 50'd367878684816948;
	localparam logic [24:0] RST_ROW_4   = 25'd16374553;

	// Wrapping step to the next row or column
	function automatic coord_t step_wrap(coord_t v);
		return (v == LAST_POS) ? 3'd0 : coord_t'(v + 3'd1);
	endfunction

	// First match in row-major order; no match gives row 0, column 0
	function automatic pos_t locate(square_t sq, letter_t v);
		pos_t pos;
		pos = '0;
		for (int r = 4; r >= 0; r--) begin
			for (int c = 4; c >= 0; c--) begin
				if (sq[r][c] == v) begin
					pos.row = coord_t'(r);
					pos.col = coord_t'(c);
				end
			end
		end
		return pos;
	endfunction

	// Square entry to upper-case ASCII, out-of-range entries clamp to Z
	function automatic ascii_t to_ascii(letter_t e);
		letter_t ec;
		ec = (e > LETTER_Z) ? LETTER_Z : e;
		return ASCII_A + ascii_t'(ec);
	endfunction

endpackage

/* design/pfde_pair_former.sv */
// Input stage: pending-letter tracking, digraph forming and the digraph register.
module pfde_pair_former import pfde_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  letter_t in_letter,
	input  logic    in_end,
	output logic    job_valid,
	input  logic    job_ready,
	output job_t    job
);

	letter_t held_letter_q;
	logic    held_valid_q;
	logic    job_valid_s1;
	job_t    job_s1;

	letter_t b;
	logic    accept;
	logic    make_job;
	job_t    job_next;
	letter_t held_letter_next;
	logic    held_valid_next;

	assign in_ready  = !job_valid_s1 || job_ready;
	assign accept    = in_valid && in_ready;
	assign job_valid = job_valid_s1;
	assign job       = job_s1;

	// j folds into i, then pair with the held letter
	always_comb begin
		b                = (in_letter == LETTER_J) ? LETTER_I : in_letter;
		make_job         = 1'b0;
		job_next.first   = held_letter_q;
		job_next.second  = LETTER_X;
		job_next.twice   = 1'b0;
		job_next.last    = in_end;
		held_letter_next = held_letter_q;
		held_valid_next  = held_valid_q;
		if (!held_valid_q) begin
			if (in_end) begin
				make_job       = 1'b1;
				job_next.first = b;
			end else begin
				held_letter_next = b;
				held_valid_next  = 1'b1;
			end
		end else if (held_letter_q == b) begin
			// doubled letter: filler x, second letter stays pending
			make_job       = 1'b1;
			job_next.twice = in_end;
		end else begin
			make_job        = 1'b1;
			job_next.second = b;
			held_valid_next = 1'b0;
		end
		if (in_end) begin
			held_valid_next  = 1'b0;
			held_letter_next = '0;
		end
	end

	// Pending letter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
		end else if (accept) begin
			held_letter_q <= held_letter_next;
			held_valid_q  <= held_valid_next;
		end
	end

	// Digraph register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			job_valid_s1 <= accept && make_job;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && make_job) begin
			job_s1 <= job_next;
		end
	end

endmodule

/* design/pfde_square_cipher.sv */
// Playfair rules on one digraph against the key square.
module pfde_square_cipher import pfde_pkg::*; (
	input  square_t square,
	input  letter_t first,
	input  letter_t second,
	output ascii_t  char0,
	output ascii_t  char1
);

	pos_t    pa;
	pos_t    pb;
	letter_t ea;
	letter_t eb;

	always_comb begin
		pa = locate(square, first);
		pb = locate(square, second);
		if (pa.row == pb.row) begin
			ea = square[pa.row][step_wrap(pa.col)];
			eb = square[pb.row][step_wrap(pb.col)];
		end else if (pa.col == pb.col) begin
			ea = square[step_wrap(pa.row)][pa.col];
			eb = square[step_wrap(pb.row)][pb.col];
		end else begin
			// rectangle: swap columns
			ea = square[pa.row][pb.col];
			eb = square[pb.row][pa.col];
		end
	end

	assign char0 = to_ascii(ea);
	assign char1 = to_ascii(eb);

endmodule

/* design/pfde_out_serializer.sv */
// Result register holding one encrypted digraph, sent out one letter per word.
module pfde_out_serializer import pfde_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load_valid,
	output logic   load_ready,
	input  ascii_t char0,
	input  ascii_t char1,
	input  logic   twice,
	input  logic   last,
	output logic   out_valid,
	input  logic   out_ready,
	output ascii_t out_char,
	output logic   out_run_last,
	output logic   out_msg_last
);

	logic       busy_q;
	logic [1:0] beat_q;
	ascii_t     char0_s2;
	ascii_t     char1_s2;
	logic       twice_s2;
	logic       last_s2;

	logic final_beat;
	logic out_fire;
	logic load;

	// Beats go c0 c1, or c0 c1 c0 c1 for a repeated digraph
	assign final_beat   = beat_q[0] && (beat_q[1] || !twice_s2);
	assign out_valid    = busy_q;
	assign out_fire     = busy_q && out_ready;
	assign out_char     = beat_q[0] ? char1_s2 : char0_s2;
	assign out_run_last = final_beat;
	assign out_msg_last = final_beat && last_s2;
	assign load_ready   = !busy_q || (out_ready && final_beat);
	assign load         = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			beat_q <= '0;
		end else if (out_fire) begin
			if (final_beat) begin
				busy_q <= 1'b0;
			end
			beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char0_s2 <= char0;
			char1_s2 <= char1;
			twice_s2 <= twice;
			last_s2  <= last;
		end
	end

endmodule

/* design/playfair_digraph_encryptor_unit.sv */
// Top level of the Playfair digraph encryptor: key square registers and stage wiring.
//
// Input stream (s_*): one plaintext letter per word, a=0 .. z=25 in
// s_tdata[4:0]; s_tlast marks the final letter of the message. j is taken as i.
// Output stream (m_*): one ciphertext letter per word as upper-case ASCII in
// m_tdata[6:0]; m_tuser is high on the last letter caused by an input word,
// m_tlast on the final letter of the message.
// Key square: written through wr_en / wr_index / wr_data; the user must do so while
// the block is idle, as the block itself does not enforce it. A letter that completes
// a digraph passes the digraph register, then the result register, before its first
// cipher letter shows. A digraph occupies the result register for 2 output words, or
// 4 when a doubled letter ends the message; the output port sets the sustained rate.
// A stalled receiver holds the current word; the digraph register and result
// register then fill and s_tready drops until words drain.
// Reset clears the pending letter, empties both stages and loads the default
// square lgdba / qmhec / urnif / xvsok / zywtp.
module playfair_digraph_encryptor_unit import pfde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] cipher_char, [7] zero
	output logic        m_tuser,   // [0] run_last
	output logic        m_tlast,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [49:0] wr_data
);

	logic [49:0] rows01_q;
	logic [49:0] rows23_q;
	logic [24:0] row4_q;
	square_t     square;

	logic   job_valid;
	logic   job_ready;
	job_t   job;
	ascii_t char0;
	ascii_t char1;
	ascii_t out_char;

	// Key square registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows01_q <= RST_ROWS_01;
			rows23_q <= RST_ROWS_23;
			row4_q   <= RST_ROW_4;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROWS_01: rows01_q <= wr_data;
				REG_ROWS_23: rows23_q <= wr_data;
				REG_ROW_4:   row4_q   <= wr_data[24:0];
				default: ;
			endcase
		end
	end

	// Unpack registers into [row][col]
	always_comb begin
		for (int c = 0; c < 5; c++) begin
			square[0][c] = rows01_q[5*c +: 5];
			square[1][c] = rows01_q[25 + 5*c +: 5];
			square[2][c] = rows23_q[5*c +: 5];
			square[3][c] = rows23_q[25 + 5*c +: 5];
			square[4][c] = row4_q[5*c +: 5];
		end
	end

	pfde_pair_former u_pair (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_letter (s_tdata[4:0]),
		.in_end    (s_tlast),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	pfde_square_cipher u_cipher (
		.square (square),
		.first  (job.first),
		.second (job.second),
		.char0  (char0),
		.char1  (char1)
	);

	pfde_out_serializer u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (job_valid),
		.load_ready   (job_ready),
		.char0        (char0),
		.char1        (char1),
		.twice        (job.twice),
		.last         (job.last),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (out_char),
		.out_run_last (m_tuser),
		.out_msg_last (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

/* test/playfair_digraph_encryptor_unit_test.sv */
// Stream-level testbench for the Playfair digraph encryptor: predictor, driver and checker.
module playfair_digraph_encryptor_unit_test import pfde_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 8;     // digraph and result registers, with margin
	localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to back up the input

	typedef struct {
		letter_t letter;
		logic    msg_end;
	} plain_word_t;

	typedef struct {
		ascii_t ch;
		logic   run_last;
		logic   msg_last;
	} cipher_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [4:0] letter, [7:5] zero
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [6:0] cipher_char, [7] zero
	logic        m_tuser;         // [0] run_last
	logic        m_tlast;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [49:0] wr_data = '0;

	playfair_digraph_encryptor_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	// Plaintext words still to drive, cipher letters still to arrive
	plain_word_t  plain_q[$];
	cipher_word_t cipher_q[$];

	// Predictor copy of the key square and the pending letter
	logic [49:0] key01 = RST_ROWS_01;
	logic [49:0] key23 = RST_ROWS_23;
	logic [24:0] key4  = RST_ROW_4;
	letter_t     held_l = '0;
	logic        held_ok = 1'b0;

	int  mismatch_cnt = 0;
	int  words_in = 0;
	int  letters_out = 0;
	int  squares_used = 1;
	bit  quiet = 1'b0;
	bit  word_taken = 1'b0;
	int  hold_req = 0;

	// ---------------- predictor ----------------

	function automatic letter_t sq_entry(int p);
		if (p < 10)
			return key01[5*p +: 5];
		else if (p < 20)
			return key23[5*(p-10) +: 5];
		return key4[5*(p-20) +: 5];
	endfunction

	// first row-major match, or entry 0 when the letter is missing
	function automatic int find_pos(letter_t v);
		for (int p = 0; p < 25; p++)
			if (sq_entry(p) == v)
				return p;
		return 0;
	endfunction

	function automatic cipher_word_t cipher_of(letter_t e);
		cipher_word_t w;
		w.ch = (e > LETTER_Z) ? 7'd90 : ascii_t'(ASCII_A + ascii_t'(e));
		w.run_last = 1'b0;
		w.msg_last = 1'b0;
		return w;
	endfunction

	task automatic encipher_pair(letter_t a, letter_t b);
		int pa, pb, ra, ca, rb, cb;
		pa = find_pos(a);
		pb = find_pos(b);
		ra = pa / 5; ca = pa % 5;
		rb = pb / 5; cb = pb % 5;
		if (ra == rb) begin
			cipher_q.push_back(cipher_of(sq_entry(ra*5 + (ca+1)%5)));
			cipher_q.push_back(cipher_of(sq_entry(rb*5 + (cb+1)%5)));
		end else if (ca == cb) begin
			cipher_q.push_back(cipher_of(sq_entry(((ra+1)%5)*5 + ca)));
			cipher_q.push_back(cipher_of(sq_entry(((rb+1)%5)*5 + cb)));
		end else begin
			cipher_q.push_back(cipher_of(sq_entry(ra*5 + cb)));
			cipher_q.push_back(cipher_of(sq_entry(rb*5 + ca)));
		end
	endtask

	task automatic encipher_word(letter_t in_l, logic fin);
		letter_t      b;
		int           n0;
		cipher_word_t tail;
		n0 = cipher_q.size();
		b = (in_l == LETTER_J) ? LETTER_I : in_l;
		if (!held_ok) begin
			if (fin)
				encipher_pair(b, LETTER_X);
			else begin
				held_l = b;
				held_ok = 1'b1;
			end
		end else if (held_l == b) begin
			// doubled letter: pad with x, the letter stays pending
			encipher_pair(held_l, LETTER_X);
			if (fin)
				encipher_pair(b, LETTER_X);
		end else begin
			encipher_pair(held_l, b);
			held_ok = 1'b0;
		end
		if (fin) begin
			held_ok = 1'b0;
			held_l = '0;
		end
		if (cipher_q.size() > n0) begin
			tail = cipher_q.pop_back();
			tail.run_last = 1'b1;
			if (fin)
				tail.msg_last = 1'b1;
			cipher_q.push_back(tail);
		end
	endtask

	// ---------------- idling ----------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------- sender ----------------

	int gap_left = 0;
	always @(negedge clk) begin : sender
		plain_word_t w;
		if (!s_tvalid || word_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (plain_q.size() > 0) begin
				w = plain_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, w.letter};
				s_tlast <= w.msg_end;
				gap_left = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- receiver ----------------

	int hold_done = 0;
	int hold_left = 0;
	int stall_left = 0;
	always @(negedge clk) begin : receiver
		if (hold_done != hold_req) begin
			hold_done = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// ---------------- monitor: config, prediction, checking ----------------

	always @(posedge clk) begin : monitor
		cipher_word_t w;
		word_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_ROWS_01: key01 = wr_data;
					REG_ROWS_23: key23 = wr_data;
					REG_ROW_4:   key4 = wr_data[24:0];
					default: ;
				endcase
			end
			// check the output word before predicting from this edge's input word
			if (m_tvalid && m_tready) begin
				letters_out++;
				if (cipher_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: unexpected word: tdata=%h tuser=%b tlast=%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					w = cipher_q.pop_front();
					if (m_tdata !== {1'b0, w.ch} || m_tuser !== w.run_last
							|| m_tlast !== w.msg_last) begin
						mismatch_cnt++;
						$display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
							$time, {1'b0, w.ch}, w.run_last, w.msg_last,
							m_tdata, m_tuser, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				words_in++;
				encipher_word(s_tdata[4:0], s_tlast);
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic add_word(letter_t l, logic e);
		plain_word_t w;
		w.letter = l;
		w.msg_end = e;
		plain_q.push_back(w);
	endtask

	// mostly whole messages with doubles, j and x mixed in; some stray words
	task automatic add_random(int count);
		int      n, len;
		letter_t prev, l;
		int      r;
		n = 0;
		prev = '0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(1, 9);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					if (k > 0 && r < 25)
						l = prev;
					else if (r < 35)
						l = LETTER_X;
					else if (r < 45)
						l = LETTER_J;
					else
						l = letter_t'($urandom_range(0, 25));
					add_word(l, k == len - 1);
					prev = l;
				end
				n += len;
			end else begin
				add_word(letter_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
				n++;
			end
		end
	endtask

	task automatic load_square(logic [49:0] r0, logic [49:0] r1, logic [49:0] r2);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_ROWS_01;
		wr_data <= r0;
		@(negedge clk);
		wr_index <= REG_ROWS_23;
		wr_data <= r1;
		@(negedge clk);
		wr_index <= REG_ROW_4;
		wr_data <= r2;
		@(negedge clk);
		wr_en <= 1'b0;
		squares_used++;
	endtask

	// random key square: 25 distinct letters without j
	task automatic load_shuffled();
		letter_t     pool[25];
		letter_t     t;
		logic [124:0] flat;
		int          k, m;
		k = 0;
		for (int v = 0; v < 26; v++)
			if (v != LETTER_J) begin
				pool[k] = letter_t'(v);
				k++;
			end
		for (int i = 24; i > 0; i--) begin
			m = $urandom_range(0, i);
			t = pool[i];
			pool[i] = pool[m];
			pool[m] = t;
		end
		for (int p = 0; p < 25; p++)
			flat[5*p +: 5] = pool[p];
		load_square(flat[49:0], flat[99:50], {25'd0, flat[124:100]});
	endtask

	// random entries: duplicates, missing letters and values above z
	task automatic load_scrambled();
		logic [124:0] flat;
		for (int p = 0; p < 25; p++)
			flat[5*p +: 5] = 5'($urandom_range(0, 31));
		load_square(flat[49:0], flat[99:50],
			{25'($urandom_range(0, 33554431)), flat[124:100]});
	endtask

	// let every word in flight come out, then give the stages time to settle
	task automatic drain_all();
		while (plain_q.size() != 0 || s_tvalid || cipher_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words on the reset square
		add_word(5'd11, 1'b0); add_word(5'd6, 1'b1);      // same row
		add_word(5'd11, 1'b0); add_word(5'd16, 1'b1);     // same column
		add_word(5'd0, 1'b0);  add_word(5'd25, 1'b1);     // rectangle
		add_word(5'd0, 1'b0);  add_word(5'd0, 1'b1);      // doubled letter at end
		add_word(LETTER_X, 1'b1);                         // lone x padded to x,x
		add_word(LETTER_X, 1'b0); add_word(LETTER_X, 1'b0); add_word(5'd1, 1'b1);
		add_word(LETTER_J, 1'b0); add_word(LETTER_I, 1'b1);  // j folds into i, doubled
		add_word(5'd25, 1'b1);
		add_word(5'd0, 1'b1);
		add_word(5'd31, 1'b0); add_word(5'd26, 1'b1);     // out-of-range letters
		add_word(5'd2, 1'b0); add_word(5'd2, 1'b0); add_word(5'd2, 1'b0);
		add_word(5'd3, 1'b1);
		add_word(LETTER_J, 1'b1);
		// random words while the receiver holds off for a long stretch
		hold_req++;
		add_random(40);
		drain_all();

		// extremes of the square
		load_square('0, '0, '0);
		add_random(15);
		drain_all();
		load_square('1, '1, '1);
		add_random(15);
		drain_all();

		// a proper square, half of it with no idling
		load_shuffled();
		quiet = 1'b1;
		add_random(25);
		drain_all();
		quiet = 1'b0;
		add_random(25);
		drain_all();

		load_scrambled();
		add_random(35);
		drain_all();

		load_shuffled();
		add_random(30);
		drain_all();

		if (cipher_q.size() != 0) begin
			mismatch_cnt++;
			$display("%0t: %0d expected words never arrived", $time, cipher_q.size());
		end
		$display("Sent %0d plaintext words over %0d key squares, checked %0d cipher letters.",
			words_in, squares_used, letters_out);
		$display("Covered doubled letters, padding, j folding, odd squares and a long stall.");
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d words still expected", $time, cipher_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
